>>> sv/otr_pkg.sv
// ----------------------------------------------------------------------------
// otr_pkg
// Shared types, codes and constants of the one-wire temperature reader.
// ----------------------------------------------------------------------------
package otr_pkg;

    // timer width default
    localparam int TIMER_BITS_DEF = 20;

    // widest configuration register
    localparam int CFG_DATA_W = 20;
    localparam int CFG_IDX_W  = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE_SAMPLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_TAIL      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_SLOT      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_SAMPLE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_TAIL       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CONVERT_WAIT    = 3'd6;

    // register reset values
    localparam logic [9:0]  RESET_LOW_DEF       = 10'd480;
    localparam logic [9:0]  PRESENCE_SAMPLE_DEF = 10'd70;
    localparam logic [9:0]  RESET_TAIL_DEF      = 10'd410;
    localparam logic [7:0]  WRITE_SLOT_DEF      = 8'd60;
    localparam logic [7:0]  READ_SAMPLE_DEF     = 8'd12;
    localparam logic [7:0]  READ_TAIL_DEF       = 8'd50;
    localparam logic [19:0] CONVERT_WAIT_DEF    = 20'd750000;

    // sequencer phase codes
    localparam logic [4:0] PH_IDLE    = 5'd0;
    localparam logic [4:0] PH_R1_LOW  = 5'd1;
    localparam logic [4:0] PH_R1_WAIT = 5'd2;
    localparam logic [4:0] PH_R1_TAIL = 5'd3;
    localparam logic [4:0] PH_W1_LOW  = 5'd4;
    localparam logic [4:0] PH_W1_DATA = 5'd5;
    localparam logic [4:0] PH_W1_REC  = 5'd6;
    localparam logic [4:0] PH_CONV    = 5'd7;
    localparam logic [4:0] PH_R2_LOW  = 5'd8;
    localparam logic [4:0] PH_R2_WAIT = 5'd9;
    localparam logic [4:0] PH_R2_TAIL = 5'd10;
    localparam logic [4:0] PH_W2_LOW  = 5'd11;
    localparam logic [4:0] PH_W2_DATA = 5'd12;
    localparam logic [4:0] PH_W2_REC  = 5'd13;
    localparam logic [4:0] PH_RD_LOW  = 5'd14;
    localparam logic [4:0] PH_RD_WAIT = 5'd15;
    localparam logic [4:0] PH_RD_TAIL = 5'd16;

    // status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NO_PRES_1  = 2'd1;
    localparam logic [1:0] ST_NO_PRES_2  = 2'd2;
    localparam logic [1:0] ST_BAD_RAW    = 2'd3;

    // raw readings that mean the sensor did not answer properly
    localparam logic [15:0] RAW_ALL_ONES  = 16'hFFFF;
    localparam logic [15:0] RAW_POWER_ON  = 16'h0550;
    localparam logic [15:0] RAW_ALL_ZEROS = 16'h0000;

    // bus commands
    localparam logic [7:0] CMD_SKIP_ROM   = 8'hCC;
    localparam logic [7:0] CMD_CONVERT    = 8'h44;
    localparam logic [7:0] CMD_READ_SCRAT = 8'hBE;

    // input request payload
    typedef struct packed {
        logic op;
        logic line_level;
    } t_in_item;

    // result payload
    typedef struct packed {
        logic               drive_low;
        logic               busy_res;
        logic               done_res;
        logic [1:0]         status;
        logic signed [15:0] temperature;
    } t_out_item;

    // timing registers handed to the sequencer
    typedef struct packed {
        logic [9:0]  reset_low_us;
        logic [9:0]  presence_sample_us;
        logic [9:0]  reset_tail_us;
        logic [7:0]  write_slot_us;
        logic [7:0]  read_sample_us;
        logic [7:0]  read_tail_us;
        logic [19:0] convert_wait_us;
    } t_cfg;

    // command byte for a write group: first group skip/convert, second skip/read
    function automatic logic [7:0] cmd_byte(input logic second, input logic idx);
        logic [7:0] b;
        if (!idx) begin
            b = CMD_SKIP_ROM;
        end else if (second) begin
            b = CMD_READ_SCRAT;
        end else begin
            b = CMD_CONVERT;
        end
        return b;
    endfunction

endpackage

>>> sv/otr_stream_if.sv
// ----------------------------------------------------------------------------
// otr_stream_if
// Valid/ready channel carrying one payload of a chosen type.
// ----------------------------------------------------------------------------
interface otr_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> sv/otr_core.sv
// ----------------------------------------------------------------------------
// otr_core
// Measurement sequencer: advances the bus phase by one tick per request and
// produces the result of that tick.
// ----------------------------------------------------------------------------
module otr_core #(
    parameter int TIMER_BITS = otr_pkg::TIMER_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  otr_pkg::t_in_item i_item,
    input  otr_pkg::t_cfg     i_cfg,
    output otr_pkg::t_out_item o_res
);

    localparam int WIDE_W = 33;
    localparam logic [WIDE_W-1:0] TIMER_MAX = (WIDE_W'(1) << TIMER_BITS) - WIDE_W'(1);

    logic [4:0]            r_phase, n_phase;
    logic [TIMER_BITS-1:0] r_timer, n_timer;
    logic [2:0]            r_bit, n_bit;
    logic [1:0]            r_byte, n_byte;
    logic [7:0]            r_shift, n_shift;
    logic [7:0]            r_low, n_low;
    logic signed [15:0]    r_temp, n_temp;
    logic [1:0]            r_stat, n_stat;

    logic [4:0]            ph_eff, ph;
    logic                  start;
    logic                  second;
    logic [TIMER_BITS-1:0] timer, dur;
    logic [TIMER_BITS:0]   timer_p1;
    logic [2:0]            bitc, bit_inc;
    logic [1:0]            bytec, byte_inc;
    logic [7:0]            shift;
    logic [7:0]            cmd;
    logic [15:0]           raw;
    logic                  drive, busy, done;

    // duration with zero counted as one tick and saturation at the timer max
    function automatic logic [TIMER_BITS-1:0] clamp_dur(
        input logic [otr_pkg::CFG_DATA_W-1:0] v
    );
        logic [WIDE_W-1:0] w;
        w = WIDE_W'(v);
        if (w == '0) begin
            w = WIDE_W'(1);
        end
        if (w > TIMER_MAX) begin
            w = TIMER_MAX;
        end
        return w[TIMER_BITS-1:0];
    endfunction

    // phase entry, start request and length of the current phase
    always_comb begin
        ph_eff = (r_phase > otr_pkg::PH_RD_TAIL) ? otr_pkg::PH_IDLE : r_phase;
        start  = (ph_eff == otr_pkg::PH_IDLE) && i_item.op;
        ph     = start ? otr_pkg::PH_R1_LOW : ph_eff;
        timer  = start ? '0 : r_timer;
        bitc   = start ? 3'd0 : r_bit;
        bytec  = start ? 2'd0 : r_byte;
        shift  = start ? 8'd0 : r_shift;
        second = (ph >= otr_pkg::PH_R2_LOW);

        priority case (ph)
            otr_pkg::PH_R1_LOW, otr_pkg::PH_R2_LOW:
                dur = clamp_dur(otr_pkg::CFG_DATA_W'(i_cfg.reset_low_us));
            otr_pkg::PH_R1_WAIT, otr_pkg::PH_R2_WAIT:
                dur = clamp_dur(otr_pkg::CFG_DATA_W'(i_cfg.presence_sample_us));
            otr_pkg::PH_R1_TAIL, otr_pkg::PH_R2_TAIL:
                dur = clamp_dur(otr_pkg::CFG_DATA_W'(i_cfg.reset_tail_us));
            otr_pkg::PH_W1_DATA, otr_pkg::PH_W2_DATA:
                dur = clamp_dur(otr_pkg::CFG_DATA_W'(i_cfg.write_slot_us));
            otr_pkg::PH_CONV:
                dur = clamp_dur(i_cfg.convert_wait_us);
            otr_pkg::PH_RD_WAIT:
                dur = clamp_dur(otr_pkg::CFG_DATA_W'(i_cfg.read_sample_us));
            otr_pkg::PH_RD_TAIL:
                dur = clamp_dur(otr_pkg::CFG_DATA_W'(i_cfg.read_tail_us));
            default:
                dur = clamp_dur(otr_pkg::CFG_DATA_W'(2));
        endcase
    end

    // line drive and next state of one tick
    always_comb begin
        n_phase  = ph;
        n_timer  = timer;
        n_bit    = bitc;
        n_byte   = bytec;
        n_shift  = shift;
        n_low    = r_low;
        n_temp   = r_temp;
        n_stat   = r_stat;
        drive    = 1'b0;
        busy     = 1'b0;
        done     = 1'b0;
        timer_p1 = {1'b0, timer} + (TIMER_BITS+1)'(1);
        bit_inc  = bitc + 3'd1;
        byte_inc = bytec + 2'd1;
        raw      = {shift, r_low};
        cmd      = otr_pkg::cmd_byte(second, bytec[0]);

        if (ph != otr_pkg::PH_IDLE) begin
            busy = 1'b1;

            // drive level
            priority case (ph)
                otr_pkg::PH_R1_LOW, otr_pkg::PH_R2_LOW, otr_pkg::PH_W1_LOW,
                otr_pkg::PH_W2_LOW, otr_pkg::PH_RD_LOW: begin
                    drive = 1'b1;
                end
                otr_pkg::PH_W1_DATA, otr_pkg::PH_W2_DATA: begin
                    drive = ~cmd[bitc];
                end
                default: begin
                    drive = 1'b0;
                end
            endcase

            // phase timer and end-of-phase transitions
            if (timer_p1 < {1'b0, dur}) begin
                n_timer = timer_p1[TIMER_BITS-1:0];
            end else begin
                n_timer = '0;
                priority case (ph)
                    otr_pkg::PH_R1_WAIT, otr_pkg::PH_R2_WAIT: begin
                        // high line at the sample means nobody answered
                        n_bit   = {2'b00, i_item.line_level};
                        n_phase = ph + 5'd1;
                    end
                    otr_pkg::PH_R1_TAIL, otr_pkg::PH_R2_TAIL: begin
                        if (bitc[0]) begin
                            n_stat  = second ? otr_pkg::ST_NO_PRES_2 : otr_pkg::ST_NO_PRES_1;
                            n_temp  = '0;
                            n_phase = otr_pkg::PH_IDLE;
                            done    = 1'b1;
                        end else begin
                            n_bit   = 3'd0;
                            n_byte  = 2'd0;
                            n_phase = ph + 5'd1;
                        end
                    end
                    otr_pkg::PH_W1_REC, otr_pkg::PH_W2_REC: begin
                        n_bit   = bit_inc;
                        n_phase = ph - 5'd2;
                        if (bit_inc == 3'd0) begin
                            n_byte = byte_inc;
                            if (byte_inc >= 2'd2) begin
                                n_byte  = 2'd0;
                                n_shift = 8'd0;
                                n_phase = second ? otr_pkg::PH_RD_LOW : otr_pkg::PH_CONV;
                            end
                        end
                    end
                    otr_pkg::PH_RD_WAIT: begin
                        n_shift = shift | (8'(i_item.line_level) << bitc);
                        n_phase = otr_pkg::PH_RD_TAIL;
                    end
                    otr_pkg::PH_RD_TAIL: begin
                        n_bit   = bit_inc;
                        n_phase = otr_pkg::PH_RD_LOW;
                        if (bit_inc == 3'd0) begin
                            if (!bytec[0]) begin
                                n_low   = shift;
                                n_shift = 8'd0;
                                n_byte  = 2'd1;
                            end else begin
                                // reject readings of a missing or unconverted sensor
                                if (raw == otr_pkg::RAW_ALL_ONES || raw == otr_pkg::RAW_POWER_ON
                                        || raw == otr_pkg::RAW_ALL_ZEROS) begin
                                    n_stat = otr_pkg::ST_BAD_RAW;
                                    n_temp = '0;
                                end else begin
                                    n_stat = otr_pkg::ST_OK;
                                    n_temp = $signed(raw);
                                end
                                n_phase = otr_pkg::PH_IDLE;
                                n_byte  = 2'd0;
                                done    = 1'b1;
                            end
                        end
                    end
                    default: begin
                        n_phase = ph + 5'd1;
                    end
                endcase
            end
        end

        o_res.drive_low   = drive;
        o_res.busy_res    = busy;
        o_res.done_res    = done;
        o_res.status      = n_stat;
        o_res.temperature = n_temp;
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= otr_pkg::PH_IDLE;
            r_timer <= '0;
            r_bit   <= 3'd0;
            r_byte  <= 2'd0;
            r_shift <= 8'd0;
            r_low   <= 8'd0;
            r_temp  <= '0;
            r_stat  <= otr_pkg::ST_OK;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_timer <= n_timer;
            r_bit   <= n_bit;
            r_byte  <= n_byte;
            r_shift <= n_shift;
            r_low   <= n_low;
            r_temp  <= n_temp;
            r_stat  <= n_stat;
        end
    end

endmodule

>>> sv/onewire_temperature_reader.sv
// ----------------------------------------------------------------------------
// onewire_temperature_reader
// One-wire bus master that runs a skip-ROM temperature measurement.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one request per microsecond tick: op (1 starts a measurement
//   when idle) and the sampled line level. o_out carries one result per
//   request: line drive, busy and done flags, last status and last raw
//   temperature in 1/16 degree.
//   Timing registers are written through i_cfg_we / i_cfg_index / i_cfg_wdata
//   while no measurement is running.
//   The result of a request is presented on the cycle after it is accepted.
//   One request per cycle while results are taken; the single sequencer step
//   between the request and the result register sets this figure.
//   The input stays ready while a result waits, as long as the downstream
//   side takes that result in the same cycle; a stalled result holds and
//   stops new requests until it is taken.
//   Reset brings the sequencer to idle, status ok, temperature zero and all
//   timing registers to their default values.
// ----------------------------------------------------------------------------
module onewire_temperature_reader #(
    parameter int TIMER_BITS = otr_pkg::TIMER_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    otr_stream_if.sink                        i_in,
    otr_stream_if.source                      o_out,
    input  logic                              i_cfg_we,
    input  logic [otr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [otr_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);

    otr_pkg::t_cfg      r_cfg;
    otr_pkg::t_out_item r_out;
    otr_pkg::t_out_item step_res;
    logic               r_out_valid;
    logic               in_ready;
    logic               in_accept;

    // handshake: accept when the result slot is empty or being drained
    assign in_ready    = !r_out_valid || o_out.ready;
    assign in_accept   = i_in.valid && in_ready;
    assign i_in.ready  = in_ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // timing registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_low_us       <= otr_pkg::RESET_LOW_DEF;
            r_cfg.presence_sample_us <= otr_pkg::PRESENCE_SAMPLE_DEF;
            r_cfg.reset_tail_us      <= otr_pkg::RESET_TAIL_DEF;
            r_cfg.write_slot_us      <= otr_pkg::WRITE_SLOT_DEF;
            r_cfg.read_sample_us     <= otr_pkg::READ_SAMPLE_DEF;
            r_cfg.read_tail_us       <= otr_pkg::READ_TAIL_DEF;
            r_cfg.convert_wait_us    <= otr_pkg::CONVERT_WAIT_DEF;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                otr_pkg::CFG_RESET_LOW:       r_cfg.reset_low_us       <= i_cfg_wdata[9:0];
                otr_pkg::CFG_PRESENCE_SAMPLE: r_cfg.presence_sample_us <= i_cfg_wdata[9:0];
                otr_pkg::CFG_RESET_TAIL:      r_cfg.reset_tail_us      <= i_cfg_wdata[9:0];
                otr_pkg::CFG_WRITE_SLOT:      r_cfg.write_slot_us      <= i_cfg_wdata[7:0];
                otr_pkg::CFG_READ_SAMPLE:     r_cfg.read_sample_us     <= i_cfg_wdata[7:0];
                otr_pkg::CFG_READ_TAIL:       r_cfg.read_tail_us       <= i_cfg_wdata[7:0];
                otr_pkg::CFG_CONVERT_WAIT:    r_cfg.convert_wait_us    <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // sequencer
    otr_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (in_accept),
        .i_item  (i_in.data),
        .i_cfg   (r_cfg),
        .o_res   (step_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out <= step_res;
        end
    end

    // assertions
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_out_valid)
        else $error("accepted request produced no result");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(in_accept && r_out_valid && !o_out.ready))
        else $error("request accepted over a stalled result");

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.done_res) |-> r_out.busy_res)
        else $error("done flagged outside a sequence");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.done_res && r_out.status != otr_pkg::ST_OK)
            |-> (r_out.temperature == '0))
        else $error("failed measurement left a temperature");

    a_ok_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.done_res && r_out.status == otr_pkg::ST_OK)
            |-> (r_out.temperature != '0))
        else $error("ok status with a rejected reading");

endmodule
